// File: hdl/ipv4_receive_header_filter_assert.svh
// ----------------------------------------------------------------------------
// IPv4 receive header filter assertion macros
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_RECEIVE_HEADER_FILTER_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_FILTER_ASSERT_SVH

// same-cycle implication
`define IPRX_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iprx assertion failed");

// next-cycle implication
`define IPRX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iprx assertion failed");

`endif

// File: hdl/iprx_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter package
// Shared widths, register indexes, verdict codes and the header snapshot type.
// ----------------------------------------------------------------------------
package iprx_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_LOCAL_ADDR  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SUBNET_MASK = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PROTO_TABLE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TABLE_COUNT = 2'd3;

  localparam logic [2:0] VERDICT_DELIVERED  = 3'd0;
  localparam logic [2:0] VERDICT_NO_HANDLER = 3'd1;
  localparam logic [2:0] VERDICT_SHORT      = 3'd2;
  localparam logic [2:0] VERDICT_VERSION    = 3'd3;
  localparam logic [2:0] VERDICT_HDR_LEN    = 3'd4;
  localparam logic [2:0] VERDICT_TOTAL_LEN  = 3'd5;
  localparam logic [2:0] VERDICT_FRAGMENT   = 3'd6;
  localparam logic [2:0] VERDICT_NOT_OURS   = 3'd7;

  localparam logic [15:0] MAX_COUNT    = 16'hFFFF;
  localparam logic [15:0] MIN_HEADER   = 16'd20;
  localparam logic [3:0]  VERSION_V4   = 4'd4;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  // byte offsets inside the IPv4 header
  localparam logic [15:0] POS_VER_IHL  = 16'd0;
  localparam logic [15:0] POS_TLEN_HI  = 16'd2;
  localparam logic [15:0] POS_TLEN_LO  = 16'd3;
  localparam logic [15:0] POS_FRAG_HI  = 16'd6;
  localparam logic [15:0] POS_FRAG_LO  = 16'd7;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_SRC_LO   = 16'd12;
  localparam logic [15:0] POS_SRC_HI   = 16'd15;
  localparam logic [15:0] POS_DST_LO   = 16'd16;
  localparam logic [15:0] POS_DST_HI   = 16'd19;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [15:0] frag_word;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } hdr_t;

endpackage

// File: hdl/iprx_in_if.sv
// ----------------------------------------------------------------------------
// IPv4 receive byte channel
// Valid/ready channel carrying one datagram byte and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface iprx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/iprx_out_if.sv
// ----------------------------------------------------------------------------
// IPv4 receive result channel
// Valid/ready channel carrying one header verdict per received frame.
// ----------------------------------------------------------------------------
interface iprx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [2:0]  handler_index;
  logic [5:0]  header_bytes;
  logic [15:0] payload_length;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [7:0]  protocol_number;

  modport source (
    output valid, output verdict, output handler_index, output header_bytes,
    output payload_length, output source_address, output destination_address,
    output protocol_number, input ready
  );
  modport sink (
    input valid, input verdict, input handler_index, input header_bytes,
    input payload_length, input source_address, input destination_address,
    input protocol_number, output ready
  );
endinterface

// File: hdl/iprx_capture.sv
// ----------------------------------------------------------------------------
// IPv4 header field capture
// Tracks the byte position, collects header fields and snapshots them at the
// end of each frame.
// ----------------------------------------------------------------------------
module iprx_capture (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  logic          take_i,
  output logic          hdr_valid_o,
  output iprx_pkg::hdr_t hdr_o
);
  import iprx_pkg::*;

  logic [15:0] pos_q, pos_d, pos_inc;
  logic [7:0]  ver_ihl_q, ver_ihl_d;
  logic [15:0] tlen_q, tlen_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic        hdr_v_q, hdr_v_d;
  hdr_t        hdr_q, hdr_d;

  assign pos_inc = (pos_q == MAX_COUNT) ? MAX_COUNT : pos_q + 16'd1;

  always_comb begin
    ver_ihl_d = ver_ihl_q;
    tlen_d    = tlen_q;
    frag_d    = frag_q;
    proto_d   = proto_q;
    src_d     = src_q;
    dst_d     = dst_q;
    if (pos_q == POS_VER_IHL) begin
      ver_ihl_d = data_byte_i;
    end else if (pos_q == POS_TLEN_HI || pos_q == POS_TLEN_LO) begin
      tlen_d = {tlen_q[7:0], data_byte_i};
    end else if (pos_q == POS_FRAG_HI || pos_q == POS_FRAG_LO) begin
      frag_d = {frag_q[7:0], data_byte_i};
    end else if (pos_q == POS_PROTO) begin
      proto_d = data_byte_i;
    end else if (pos_q >= POS_SRC_LO && pos_q <= POS_SRC_HI) begin
      src_d = {src_q[23:0], data_byte_i};
    end else if (pos_q >= POS_DST_LO && pos_q <= POS_DST_HI) begin
      dst_d = {dst_q[23:0], data_byte_i};
    end
  end

  always_comb begin
    pos_d   = pos_q;
    hdr_v_d = hdr_v_q;
    hdr_d   = hdr_q;
    if (take_i) begin
      hdr_v_d = 1'b0;
    end
    if (fire_i) begin
      if (last_byte_i) begin
        pos_d           = '0;
        hdr_v_d         = 1'b1;
        hdr_d.frame_len = pos_inc;
        hdr_d.ver_ihl   = ver_ihl_d;
        hdr_d.tot_len   = tlen_d;
        hdr_d.frag_word = frag_d;
        hdr_d.proto     = proto_d;
        hdr_d.src_addr  = src_d;
        hdr_d.dst_addr  = dst_d;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ver_ihl_q <= '0;
      tlen_q    <= '0;
      frag_q    <= '0;
      proto_q   <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      hdr_v_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      hdr_v_q <= hdr_v_d;
      if (fire_i) begin
        if (last_byte_i) begin
          ver_ihl_q <= '0;
          tlen_q    <= '0;
          frag_q    <= '0;
          proto_q   <= '0;
          src_q     <= '0;
          dst_q     <= '0;
        end else begin
          ver_ihl_q <= ver_ihl_d;
          tlen_q    <= tlen_d;
          frag_q    <= frag_d;
          proto_q   <= proto_d;
          src_q     <= src_d;
          dst_q     <= dst_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  assign hdr_valid_o = hdr_v_q;
  assign hdr_o       = hdr_q;

endmodule

// File: hdl/ipv4_receive_header_filter.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter
// The last byte is snapshotted at its accepting edge, and the verdict is
// registered from that snapshot once the result register is empty or being read.
// Throughput: one byte per cycle while the result channel does not stall; one verdict per frame, frames back to back.
// Reset clears configuration, byte position, captured fields and valid flags.
// ----------------------------------------------------------------------------
`include "ipv4_receive_header_filter_assert.svh"

module ipv4_receive_header_filter #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [iprx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iprx_pkg::CfgDataW-1:0]  cfg_wdata_i,
  iprx_in_if.sink                        rx_i,
  iprx_out_if.source                     res_o
);
  import iprx_pkg::*;

  logic [31:0] local_addr_q;
  logic [31:0] mask_q;
  logic [7:0]  tab_q [TABLE_ENTRIES];
  logic [3:0]  count_q;

  logic        rx_fire;
  logic        take;
  logic        hdr_v;
  hdr_t        hdr;

  logic        out_v_q;
  logic [2:0]  verdict_q, verdict_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [5:0]  hbytes_q, hbytes_d;
  logic [15:0] plen_q, plen_d;
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [7:0]  proto_q;

  logic [3:0]  n_eff;
  logic        match;
  logic [2:0]  match_idx;
  logic [15:0] ihl16;
  logic [31:0] bcast;
  logic        ours;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      mask_q       <= '0;
      count_q      <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tab_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCAL_ADDR:  local_addr_q <= cfg_wdata_i[31:0];
        REG_SUBNET_MASK: mask_q <= cfg_wdata_i[31:0];
        REG_PROTO_TABLE: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tab_q[i] <= cfg_wdata_i[8*i +: 8];
          end
        end
        REG_TABLE_COUNT: count_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign take       = hdr_v && (!out_v_q || res_o.ready);
  assign rx_i.ready = !hdr_v || take;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  iprx_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (rx_fire),
    .data_byte_i (rx_i.data_byte),
    .last_byte_i (rx_i.last_byte),
    .take_i      (take),
    .hdr_valid_o (hdr_v),
    .hdr_o       (hdr)
  );

  // protocol table lookup, lowest entry wins
  assign n_eff = (count_q > 4'(TABLE_ENTRIES)) ? 4'(TABLE_ENTRIES) : count_q;

  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (4'(i) < n_eff && tab_q[i] == hdr.proto) begin
        match     = 1'b1;
        match_idx = 3'(i);
      end
    end
  end

  assign hbytes_d = {hdr.ver_ihl[3:0], 2'b00};
  assign ihl16    = {10'd0, hbytes_d};
  assign bcast    = (local_addr_q & mask_q) | ~mask_q;
  assign ours     = (local_addr_q == '0) || (hdr.dst_addr == local_addr_q) ||
                    (hdr.dst_addr == bcast) || (hdr.dst_addr == ALL_ONES);

  always_comb begin
    hidx_d = '0;
    plen_d = '0;
    if (hdr.frame_len < MIN_HEADER) begin
      verdict_d = VERDICT_SHORT;
    end else if (hdr.ver_ihl[7:4] != VERSION_V4) begin
      verdict_d = VERDICT_VERSION;
    end else if (ihl16 < MIN_HEADER || ihl16 > hdr.frame_len) begin
      verdict_d = VERDICT_HDR_LEN;
    end else if (hdr.tot_len < ihl16 || hdr.tot_len > hdr.frame_len) begin
      verdict_d = VERDICT_TOTAL_LEN;
    end else if (hdr.frag_word[13:0] != '0) begin
      verdict_d = VERDICT_FRAGMENT;
    end else if (!ours) begin
      verdict_d = VERDICT_NOT_OURS;
    end else begin
      plen_d = hdr.tot_len - ihl16;
      if (match) begin
        verdict_d = VERDICT_DELIVERED;
        hidx_d    = match_idx;
      end else begin
        verdict_d = VERDICT_NO_HANDLER;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      verdict_q <= verdict_d;
      hidx_q    <= hidx_d;
      hbytes_q  <= hbytes_d;
      plen_q    <= plen_d;
      src_q     <= hdr.src_addr;
      dst_q     <= hdr.dst_addr;
      proto_q   <= hdr.proto;
    end
  end

  assign res_o.valid               = out_v_q;
  assign res_o.verdict             = verdict_q;
  assign res_o.handler_index       = hidx_q;
  assign res_o.header_bytes        = hbytes_q;
  assign res_o.payload_length      = plen_q;
  assign res_o.source_address      = src_q;
  assign res_o.destination_address = dst_q;
  assign res_o.protocol_number     = proto_q;

  `IPRX_ASSERT_SAME(a_hidx_only_delivered, out_v_q && verdict_q != VERDICT_DELIVERED, hidx_q == '0)
  `IPRX_ASSERT_SAME(a_plen_zero_rejected, out_v_q && verdict_q > VERDICT_NO_HANDLER, plen_q == '0)
  `IPRX_ASSERT_SAME(a_stall_blocks_input, hdr_v && out_v_q && !res_o.ready, !rx_i.ready)
  `IPRX_ASSERT_NEXT(a_last_fills_snapshot, rx_fire && rx_i.last_byte, hdr_v)

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter testbench
// Streams datagram bytes through the receive channel and checks every verdict
// against an in-bench header parser, over several address and protocol table
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import iprx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_byte_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [2:0]  handler;
    logic [5:0]  hdr_bytes;
    logic [15:0] payload;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
  } rx_verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  iprx_in_if  rx_if ();
  iprx_out_if res_if ();

  ipv4_receive_header_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  // configuration as last written
  logic [31:0] my_addr;
  logic [31:0] my_mask;
  logic [63:0] proto_table;
  logic [3:0]  proto_count;

  // header capture state of the parser
  logic [15:0] rx_pos;
  logic [7:0]  rx_ver_ihl;
  logic [15:0] rx_tlen;
  logic [15:0] rx_frag;
  logic [7:0]  rx_proto;
  logic [31:0] rx_src;
  logic [31:0] rx_dst;

  rx_byte_t    rx_pending[$];
  rx_verdict_t verdicts_due[$];
  rx_byte_t    rx_next;
  rx_verdict_t res_got;
  rx_verdict_t res_want;

  bit          rx_steady;
  bit          res_steady;
  int unsigned rx_gap;
  int unsigned res_stall;
  int unsigned res_draw;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ipv4_receive_header_filter test failed");
      $finish;
    end
  end

  task automatic parse_rx_byte(input logic [7:0] b, input logic lst);
    int unsigned flen;
    int unsigned ihl;
    int unsigned tot;
    int unsigned n;
    int unsigned k;
    logic [31:0] bcast;
    rx_verdict_t v;
    case (rx_pos)
      POS_VER_IHL:              rx_ver_ihl = b;
      POS_TLEN_HI, POS_TLEN_LO: rx_tlen = {rx_tlen[7:0], b};
      POS_FRAG_HI, POS_FRAG_LO: rx_frag = {rx_frag[7:0], b};
      POS_PROTO:                rx_proto = b;
      default: begin
        if (rx_pos >= POS_SRC_LO && rx_pos <= POS_SRC_HI) rx_src = {rx_src[23:0], b};
        else if (rx_pos >= POS_DST_LO && rx_pos <= POS_DST_HI) rx_dst = {rx_dst[23:0], b};
      end
    endcase
    if (!lst) begin
      if (rx_pos != MAX_COUNT) rx_pos = rx_pos + 16'd1;
      return;
    end
    flen = rx_pos + 1;
    if (flen > MAX_COUNT) flen = MAX_COUNT;
    ihl = 4 * rx_ver_ihl[3:0];
    tot = rx_tlen;
    v = '0;
    v.hdr_bytes = ihl[5:0];
    v.src = rx_src;
    v.dst = rx_dst;
    v.proto = rx_proto;
    if (flen < MIN_HEADER) v.verdict = VERDICT_SHORT;
    else if (rx_ver_ihl[7:4] != VERSION_V4) v.verdict = VERDICT_VERSION;
    else if (ihl < MIN_HEADER || ihl > flen) v.verdict = VERDICT_HDR_LEN;
    else if (tot < ihl || tot > flen) v.verdict = VERDICT_TOTAL_LEN;
    else if (rx_frag[12:0] != 13'd0 || rx_frag[13]) v.verdict = VERDICT_FRAGMENT;
    else begin
      bcast = (my_addr & my_mask) | ~my_mask;
      if (my_addr != 32'd0 && rx_dst != my_addr && rx_dst != bcast && rx_dst != ALL_ONES) begin
        v.verdict = VERDICT_NOT_OURS;
      end else begin
        v.payload = 16'(tot - ihl);
        v.verdict = VERDICT_NO_HANDLER;
        n = (proto_count > 8) ? 8 : proto_count;
        k = 0;
        while (k < n && v.verdict != VERDICT_DELIVERED) begin
          if (proto_table[8*k +: 8] == rx_proto) begin
            v.verdict = VERDICT_DELIVERED;
            v.handler = 3'(k);
          end
          k++;
        end
      end
    end
    verdicts_due.push_back(v);
    rx_pos = '0;
    rx_ver_ihl = '0;
    rx_tlen = '0;
    rx_frag = '0;
    rx_proto = '0;
    rx_src = '0;
    rx_dst = '0;
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      rx_if.data_byte <= '0;
      rx_if.last_byte <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (rx_if.valid && rx_if.ready) parse_rx_byte(rx_if.data_byte, rx_if.last_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_gap != 0) begin
          rx_gap <= rx_gap - 1;
          rx_if.valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          rx_next = rx_pending.pop_front();
          rx_if.valid <= 1'b1;
          rx_if.data_byte <= rx_next.data;
          rx_if.last_byte <= rx_next.last;
          rx_gap <= rx_steady ? 0 : $urandom_range(0, 9);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_stall <= 0;
    end else if (res_if.valid && res_if.ready) begin
      res_got = {res_if.verdict, res_if.handler_index, res_if.header_bytes,
                 res_if.payload_length, res_if.source_address, res_if.destination_address,
                 res_if.protocol_number};
      if (verdicts_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected transaction: verdict %0d src %h dst %h", res_got.verdict,
                   res_got.src, res_got.dst);
      end else begin
        res_want = verdicts_due.pop_front();
        if (res_got !== res_want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch (exp/got): verdict %0d/%0d handler %0d/%0d hdr %0d/%0d",
                     res_want.verdict, res_got.verdict, res_want.handler, res_got.handler,
                     res_want.hdr_bytes, res_got.hdr_bytes);
            $display("  payload %0d/%0d src %h/%h dst %h/%h proto %0d/%0d",
                     res_want.payload, res_got.payload, res_want.src, res_got.src,
                     res_want.dst, res_got.dst, res_want.proto, res_got.proto);
          end
        end
      end
      res_draw = res_steady ? 0 : $urandom_range(0, 9);
      res_stall <= res_draw;
      res_if.ready <= (res_draw == 0);
    end else if (res_stall != 0) begin
      res_stall <= res_stall - 1;
      res_if.ready <= (res_stall == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LOCAL_ADDR:  my_addr = val[31:0];
      REG_SUBNET_MASK: my_mask = val[31:0];
      REG_PROTO_TABLE: proto_table = val;
      REG_TABLE_COUNT: proto_count = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] addr, input logic [31:0] mask,
                            input logic [63:0] tbl, input logic [3:0] cnt);
    write_reg(REG_LOCAL_ADDR, {32'd0, addr});
    write_reg(REG_SUBNET_MASK, {32'd0, mask});
    write_reg(REG_PROTO_TABLE, tbl);
    write_reg(REG_TABLE_COUNT, {60'd0, cnt});
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (rx_pending.size() != 0 || rx_if.valid || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // header fields land at their offsets, everything else is random filler
  task automatic queue_frame(input logic [7:0] vi, input logic [15:0] tl,
                             input logic [15:0] fw, input logic [7:0] pr,
                             input logic [31:0] sa, input logic [31:0] da,
                             input int unsigned flen);
    rx_byte_t    item;
    logic [15:0] p;
    int unsigned i;
    for (i = 0; i < flen; i++) begin
      item.data = 8'($urandom_range(0, 255));
      item.last = (i == flen - 1);
      if (i < 20) begin
        p = 16'(i);
        case (p)
          POS_VER_IHL: item.data = vi;
          POS_TLEN_HI: item.data = tl[15:8];
          POS_TLEN_LO: item.data = tl[7:0];
          POS_FRAG_HI: item.data = fw[15:8];
          POS_FRAG_LO: item.data = fw[7:0];
          POS_PROTO:   item.data = pr;
          default: begin
            if (p >= POS_SRC_LO && p <= POS_SRC_HI) item.data = sa[8*(POS_SRC_HI-p) +: 8];
            else if (p >= POS_DST_LO && p <= POS_DST_HI) item.data = da[8*(POS_DST_HI-p) +: 8];
          end
        endcase
      end
      rx_pending.push_back(item);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_bytes;
    int unsigned rand_bytes;
    int unsigned rand_frames;
    int unsigned kind;
    int unsigned ihl_w;
    int unsigned tl_i;
    int unsigned flen;
    int unsigned k;
    int unsigned j;
    logic [7:0]  vi;
    logic [7:0]  pr;
    logic [15:0] fw;
    logic [31:0] sa;
    logic [31:0] da;
    logic [31:0] bc;
    logic [31:0] ca;
    logic [31:0] cm;
    logic [63:0] ct;
    logic [3:0]  cn;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rx_if.valid = 1'b0;
    rx_if.data_byte = '0;
    rx_if.last_byte = 1'b0;
    res_if.ready = 1'b0;
    my_addr = '0;
    my_mask = '0;
    proto_table = '0;
    proto_count = '0;
    rx_pos = '0;
    rx_ver_ihl = '0;
    rx_tlen = '0;
    rx_frag = '0;
    rx_proto = '0;
    rx_src = '0;
    rx_dst = '0;
    error_count = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: every destination accepted, empty table
    queue_frame(8'hFF, 16'd0, 16'd0, 8'd0, 32'd0, 32'd0, 1);
    queue_frame(8'h45, 16'd19, 16'd0, 8'd6, 32'h0A000001, 32'h0A000002, 19);
    queue_frame(8'h65, 16'd20, 16'd0, 8'd6, 32'h0A000001, 32'h0A000002, 20);
    queue_frame(8'h44, 16'd20, 16'd0, 8'd6, 32'h0A000001, 32'h0A000002, 20);
    queue_frame(8'h4F, 16'd60, 16'd0, 8'd6, 32'h0A000001, 32'h0A000002, 40);
    queue_frame(8'h45, 16'd19, 16'd0, 8'd6, 32'h0A000001, 32'h0A000002, 20);
    queue_frame(8'h45, 16'd21, 16'd0, 8'd6, 32'h0A000001, 32'h0A000002, 20);
    queue_frame(8'h45, 16'd20, 16'h0001, 8'd6, 32'h0A000001, 32'h0A000002, 20);
    queue_frame(8'h45, 16'd20, 16'h2000, 8'd6, 32'h0A000001, 32'h0A000002, 20);
    queue_frame(8'h45, 16'd20, 16'h4000, 8'd17, 32'hFFFFFFFF, 32'h12345678, 20);
    queue_frame(8'h4F, 16'd68, 16'd0, 8'd0, 32'h00000000, 32'hFFFFFFFF, 70);
    wait_idle();

    // unicast, subnet broadcast, all-ones, foreign; first table match wins
    set_config(32'hC0A80105, 32'hFFFFFF00, 64'h592FFF00_06011106, 4'd8);
    queue_frame(8'h45, 16'd20, 16'd0, 8'd6, 32'h0A000001, 32'hC0A80105, 20);
    queue_frame(8'h45, 16'd24, 16'd0, 8'h59, 32'h0A000001, 32'hC0A801FF, 24);
    queue_frame(8'h45, 16'd20, 16'd0, 8'h32, 32'h0A000001, 32'hFFFFFFFF, 22);
    queue_frame(8'h45, 16'd20, 16'd0, 8'd6, 32'h0A000001, 32'hC0A80205, 20);
    queue_frame(8'h45, 16'd20, 16'd0, 8'd6, 32'h0A000001, 32'h00000000, 20);
    wait_idle();
    write_reg(REG_TABLE_COUNT, 64'd3);
    queue_frame(8'h45, 16'd20, 16'd0, 8'hFF, 32'h0A000001, 32'hC0A80105, 20);
    queue_frame(8'h45, 16'd20, 16'd0, 8'd1, 32'h0A000001, 32'hC0A80105, 20);
    wait_idle();
    write_reg(REG_TABLE_COUNT, 64'd15);
    queue_frame(8'h45, 16'd20, 16'd0, 8'hFF, 32'h0A000001, 32'hC0A80105, 20);
    wait_idle();

    phase = 0;
    rand_bytes = 0;
    rand_frames = 0;
    while (rand_bytes < 800 || rand_frames < 40) begin
      case (phase)
        0: begin
          ca = ALL_ONES;
          cm = 32'd0;
          ct = {8{8'hFF}};
          cn = 4'd15;
        end
        1: begin
          ca = 32'd1;
          cm = ALL_ONES;
          ct = '0;
          cn = 4'd8;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       ca = 32'd0;
            1:       ca = ALL_ONES;
            default: ca = $urandom;
          endcase
          k = $urandom_range(0, 32);
          cm = (k == 0) ? 32'd0 : ALL_ONES << (32 - k);
          for (j = 0; j < 8; j++)
            ct[8*j +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 20))
                                                : 8'($urandom_range(0, 255));
          cn = 4'($urandom_range(0, 15));
        end
      endcase
      set_config(ca, cm, ct, cn);
      rx_steady = ($urandom_range(0, 3) == 0);
      res_steady = ($urandom_range(0, 3) == 0);
      phase_bytes = 0;
      while (phase_bytes < 200) begin
        kind = $urandom_range(0, 9);
        ihl_w = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        tl_i = ihl_w * 4 + $urandom_range(0, 12);
        flen = tl_i + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        vi = {VERSION_V4, 4'(ihl_w)};
        case ($urandom_range(0, 5))
          0:       fw = 16'h4000;
          1:       fw = 16'($urandom);
          default: fw = 16'd0;
        endcase
        pr = $urandom_range(0, 1) ? proto_table[8*$urandom_range(0, 7) +: 8]
                                  : 8'($urandom_range(0, 255));
        bc = (my_addr & my_mask) | ~my_mask;
        case ($urandom_range(0, 4))
          0:       da = my_addr;
          1:       da = bc;
          2:       da = ALL_ONES;
          default: da = $urandom;
        endcase
        sa = $urandom;
        if (kind == 6 || kind == 7) begin
          case ($urandom_range(0, 3))
            0: begin
              vi[7:4] = 4'($urandom_range(0, 15));
              if (vi[7:4] == VERSION_V4) vi[7:4] = 4'd6;
            end
            1: vi[3:0] = 4'($urandom_range(0, 4));
            2: tl_i = $urandom_range(0, 1) ? $urandom_range(0, ihl_w * 4 - 1)
                                           : flen + $urandom_range(1, 200);
            default: flen = $urandom_range(1, 19);
          endcase
        end else if (kind >= 8) begin
          vi = 8'($urandom_range(0, 255));
          tl_i = $urandom_range(0, 65535);
          fw = 16'($urandom);
          flen = $urandom_range(1, 40);
        end
        queue_frame(vi, 16'(tl_i), fw, pr, sa, da, flen);
        phase_bytes += flen;
        rand_bytes += flen;
        rand_frames++;
      end
      wait_idle();
      phase++;
    end

    if (error_count == 0) begin
      $display("ipv4_receive_header_filter test passed");
    end else begin
      $display("ipv4_receive_header_filter test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/iprx_pkg.sv
hdl/iprx_in_if.sv
hdl/iprx_out_if.sv
hdl/iprx_capture.sv
hdl/ipv4_receive_header_filter.sv
bench/tb_top.sv
